FILE: hw/rtl/modular_square_root_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MODULAR_SQUARE_ROOT_CORE_DEFINES_SVH
`define MODULAR_SQUARE_ROOT_CORE_DEFINES_SVH

// Same-cycle implication, reset masked
`define MSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define MSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well
`define MSR_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/msr_pkg.sv
package msr_pkg;

    // Defaults for the top-level parameters
    localparam int WORD_BITS_DEF   = 32;
    localparam int SEARCH_LIMIT_DEF = 1024;

    // Fixed field widths and stream widths
    localparam int FIELD_BITS = 32;
    localparam int S_TDATA_W  = 64;   // residue, modulus
    localparam int M_TDATA_W  = 72;   // root_first, root_second, ok, zero pad
    localparam int OK_BIT     = 64;

endpackage

FILE: hw/rtl/msr_mulmod.sv
// Bit-serial modular multiplier: product = op_a * op_b mod modulus.
// MSB first; each bit of op_b takes a double step, then a conditional add step.
// Requires op_a < modulus; op_b may be any value.
module msr_mulmod #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic [W-1:0] modulus,
    output logic         done,
    output logic [W-1:0] product
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  acc_reg, a_reg, b_reg;
    logic [CW-1:0] cnt_reg;
    logic          phase_reg, busy_reg, done_reg;
    logic [W:0]    dbl, dbl_red, sum, sum_red;

    // Double and add candidates, each with one compare-subtract reduction
    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
        sum     = {1'b0, acc_reg} + {1'b0, a_reg};
        sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            acc_reg   <= '0;
            a_reg     <= op_a;
            b_reg     <= op_b;
            cnt_reg   <= CW'(W - 1);
        end else if (busy_reg) begin
            if (!phase_reg) begin
                acc_reg   <= dbl_red[W-1:0];
                phase_reg <= 1'b1;
                done_reg  <= 1'b0;
            end else begin
                if (b_reg[W-1]) begin
                    acc_reg <= sum_red[W-1:0];
                end
                b_reg     <= {b_reg[W-2:0], 1'b0};
                phase_reg <= 1'b0;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg  <= cnt_reg - 1'b1;
                    done_reg <= 1'b0;
                end
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hw/rtl/modular_square_root_core.sv
// Channel  Dir  Width  Contents (low bit first)
// s_       in   64     residue[31:0], modulus[63:32]
// m_       out  72     root_first[31:0], root_second[63:32], ok[64], zero pad
//
// One transaction at a time; a power takes up to 2*(WORD_BITS-1) multiplies.
// A full transaction costs the Euler power, one power per non-residue candidate, three
// more powers and the root loop's multiplies.
// Reset (aresetn low, synchronous) empties the output register and idles the sequencer.
// s_tready is high only in idle; a stalled result blocks only the next result.
module modular_square_root_core #(
    parameter int WORD_BITS               = msr_pkg::WORD_BITS_DEF,
    parameter int NONRESIDUE_SEARCH_LIMIT = msr_pkg::SEARCH_LIMIT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [msr_pkg::S_TDATA_W-1:0]  s_tdata,   // residue, modulus
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msr_pkg::M_TDATA_W-1:0]  m_tdata    // root_first, root_second, ok
);
    import msr_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int SW = $clog2(W);
    localparam int KW = $clog2(NONRESIDUE_SEARCH_LIMIT + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MWAIT, S_POW, S_PDONE, S_FACT, S_SEARCH,
        S_LOOP, S_ISRCH, S_BSQ, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        MT_RED, MT_PACC, MT_PBASE, MT_TT, MT_B, MT_R, MT_T1, MT_T2, MT_C, MT_FIN
    } mtag_t;

    typedef enum logic [2:0] {
        PT_EULER, PT_SEARCH, PT_C, PT_R, PT_T
    } ptag_t;

    state_t        state_reg;
    mtag_t         mtag_reg;
    ptag_t         ptag_reg;
    logic [W-1:0]  n_reg, p_reg, nr_reg, q_reg, z_reg, c_reg, r_reg, t_reg;
    logic [W-1:0]  b_reg, tt_reg, pacc_reg, pbase_reg, pex_reg, ma_reg, mb_reg;
    logic [SW-1:0] s_reg, mm_reg, i_reg, j_reg;
    logic [KW-1:0] k_reg;
    logic [W-1:0]  rf_reg, rs_reg;
    logic          rok_reg, mstart_reg;
    logic [FIELD_BITS-1:0] of_reg, os_reg;
    logic          ook_reg, ovalid_reg;

    logic          mdone;
    logic [W-1:0]  mres;
    logic [W-1:0]  half, pm1;

    assign pm1  = p_reg - 1'b1;
    assign half = {1'b0, p_reg[W-1:1]};

    msr_mulmod #(.W(W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mstart_reg),
        .op_a    (ma_reg),
        .op_b    (mb_reg),
        .modulus (p_reg),
        .done    (mdone),
        .product (mres)
    );

    // Sequencer, shared multiplier calls, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            mstart_reg <= 1'b0;
        end else begin
            // S_OUT reloads the register itself when it is freed
            if (ovalid_reg && m_tready && state_reg != S_OUT) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    mstart_reg <= 1'b0;
                    if (s_tvalid) begin
                        n_reg     <= s_tdata[W-1:0];
                        p_reg     <= s_tdata[FIELD_BITS+W-1:FIELD_BITS];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    rf_reg  <= '0;
                    rs_reg  <= '0;
                    rok_reg <= 1'b0;
                    priority if (p_reg < W'(2)) begin
                        mstart_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end else if (p_reg == W'(2)) begin
                        rf_reg     <= n_reg;
                        rs_reg     <= n_reg;
                        rok_reg    <= n_reg[0];
                        mstart_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end else if (!p_reg[0]) begin
                        mstart_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end else begin
                        // n mod p as 1 * n through the multiplier
                        ma_reg     <= W'(1);
                        mb_reg     <= n_reg;
                        mtag_reg   <= MT_RED;
                        mstart_reg <= 1'b1;
                        state_reg  <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    if (mdone) begin
                        unique case (mtag_reg)
                            MT_RED: begin
                                nr_reg     <= mres;
                                mstart_reg <= 1'b0;
                                if (mres == '0) begin
                                    state_reg <= S_OUT;
                                end else begin
                                    pacc_reg  <= W'(1);
                                    pbase_reg <= mres;
                                    pex_reg   <= half;
                                    ptag_reg  <= PT_EULER;
                                    state_reg <= S_POW;
                                end
                            end
                            MT_PACC: begin
                                pacc_reg   <= mres;
                                ma_reg     <= pbase_reg;
                                mb_reg     <= pbase_reg;
                                mtag_reg   <= MT_PBASE;
                                mstart_reg <= 1'b1;
                            end
                            MT_PBASE: begin
                                pbase_reg  <= mres;
                                pex_reg    <= {1'b0, pex_reg[W-1:1]};
                                mstart_reg <= 1'b0;
                                state_reg  <= S_POW;
                            end
                            MT_TT: begin
                                tt_reg     <= mres;
                                mstart_reg <= 1'b0;
                                state_reg  <= S_ISRCH;
                            end
                            MT_B: begin
                                b_reg      <= mres;
                                mstart_reg <= 1'b0;
                                state_reg  <= S_BSQ;
                            end
                            MT_R: begin
                                r_reg      <= mres;
                                ma_reg     <= t_reg;
                                mb_reg     <= b_reg;
                                mtag_reg   <= MT_T1;
                                mstart_reg <= 1'b1;
                            end
                            MT_T1: begin
                                ma_reg     <= mres;
                                mb_reg     <= b_reg;
                                mtag_reg   <= MT_T2;
                                mstart_reg <= 1'b1;
                            end
                            MT_T2: begin
                                t_reg      <= mres;
                                ma_reg     <= b_reg;
                                mb_reg     <= b_reg;
                                mtag_reg   <= MT_C;
                                mstart_reg <= 1'b1;
                            end
                            MT_C: begin
                                c_reg      <= mres;
                                mm_reg     <= i_reg;
                                mstart_reg <= 1'b0;
                                state_reg  <= S_LOOP;
                            end
                            MT_FIN: begin
                                if (mres == nr_reg) begin
                                    rf_reg  <= r_reg;
                                    rs_reg  <= p_reg - r_reg;
                                    rok_reg <= 1'b1;
                                end
                                mstart_reg <= 1'b0;
                                state_reg  <= S_OUT;
                            end
                            default: begin
                                mstart_reg <= 1'b0;
                                state_reg  <= S_OUT;
                            end
                        endcase
                    end else begin
                        mstart_reg <= 1'b0;
                    end
                end
                // Square-and-multiply, exponent consumed LSB first
                S_POW: begin
                    if (pex_reg == '0) begin
                        mstart_reg <= 1'b0;
                        state_reg  <= S_PDONE;
                    end else begin
                        ma_reg     <= pex_reg[0] ? pacc_reg : pbase_reg;
                        mb_reg     <= pbase_reg;
                        mtag_reg   <= pex_reg[0] ? MT_PACC : MT_PBASE;
                        mstart_reg <= 1'b1;
                        state_reg  <= S_MWAIT;
                    end
                end
                S_PDONE: begin
                    mstart_reg <= 1'b0;
                    unique case (ptag_reg)
                        PT_EULER: begin
                            if (pacc_reg != W'(1)) begin
                                state_reg <= S_OUT;
                            end else begin
                                q_reg     <= pm1;
                                s_reg     <= '0;
                                state_reg <= S_FACT;
                            end
                        end
                        PT_SEARCH: begin
                            if (pacc_reg == pm1) begin
                                pacc_reg  <= W'(1);
                                pbase_reg <= z_reg;
                                pex_reg   <= q_reg;
                                ptag_reg  <= PT_C;
                                state_reg <= S_POW;
                            end else begin
                                k_reg     <= k_reg + 1'b1;
                                z_reg     <= z_reg + 1'b1;
                                state_reg <= S_SEARCH;
                            end
                        end
                        PT_C: begin
                            c_reg     <= pacc_reg;
                            pacc_reg  <= W'(1);
                            pbase_reg <= nr_reg;
                            pex_reg   <= W'((q_reg + 1'b1) >> 1);
                            ptag_reg  <= PT_R;
                            state_reg <= S_POW;
                        end
                        PT_R: begin
                            r_reg     <= pacc_reg;
                            pacc_reg  <= W'(1);
                            pbase_reg <= nr_reg;
                            pex_reg   <= q_reg;
                            ptag_reg  <= PT_T;
                            state_reg <= S_POW;
                        end
                        PT_T: begin
                            t_reg     <= pacc_reg;
                            mm_reg    <= s_reg;
                            state_reg <= S_LOOP;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                // Strip factors of two from p-1
                S_FACT: begin
                    mstart_reg <= 1'b0;
                    if (!q_reg[0]) begin
                        q_reg <= {1'b0, q_reg[W-1:1]};
                        s_reg <= s_reg + 1'b1;
                    end else begin
                        k_reg     <= '0;
                        z_reg     <= W'(2);
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    mstart_reg <= 1'b0;
                    if (k_reg == KW'(NONRESIDUE_SEARCH_LIMIT) || z_reg >= p_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        pacc_reg  <= W'(1);
                        pbase_reg <= z_reg;
                        pex_reg   <= half;
                        ptag_reg  <= PT_SEARCH;
                        state_reg <= S_POW;
                    end
                end
                S_LOOP: begin
                    ma_reg     <= (t_reg == W'(1)) ? r_reg : t_reg;
                    mb_reg     <= (t_reg == W'(1)) ? r_reg : t_reg;
                    mtag_reg   <= (t_reg == W'(1)) ? MT_FIN : MT_TT;
                    i_reg      <= SW'(1);
                    mstart_reg <= 1'b1;
                    state_reg  <= S_MWAIT;
                end
                // Least i with t^(2^i) == 1
                S_ISRCH: begin
                    priority if (i_reg < mm_reg && tt_reg != W'(1)) begin
                        i_reg      <= i_reg + 1'b1;
                        ma_reg     <= tt_reg;
                        mb_reg     <= tt_reg;
                        mtag_reg   <= MT_TT;
                        mstart_reg <= 1'b1;
                        state_reg  <= S_MWAIT;
                    end else if (i_reg >= mm_reg) begin
                        mstart_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end else begin
                        b_reg      <= c_reg;
                        j_reg      <= mm_reg - i_reg - 1'b1;
                        mstart_reg <= 1'b0;
                        state_reg  <= S_BSQ;
                    end
                end
                S_BSQ: begin
                    if (j_reg != '0) begin
                        j_reg    <= j_reg - 1'b1;
                        ma_reg   <= b_reg;
                        mb_reg   <= b_reg;
                        mtag_reg <= MT_B;
                    end else begin
                        ma_reg   <= r_reg;
                        mb_reg   <= b_reg;
                        mtag_reg <= MT_R;
                    end
                    mstart_reg <= 1'b1;
                    state_reg  <= S_MWAIT;
                end
                S_OUT: begin
                    mstart_reg <= 1'b0;
                    if (!ovalid_reg || m_tready) begin
                        of_reg     <= FIELD_BITS'(rf_reg);
                        os_reg     <= FIELD_BITS'(rs_reg);
                        ook_reg    <= rok_reg;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    mstart_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(M_TDATA_W - OK_BIT - 1){1'b0}}, ook_reg, os_reg, of_reg};

endmodule

FILE: hw/rtl/msr_checker.sv
`include "modular_square_root_core_defines.svh"

// Port-level checks on the result channel
module msr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [msr_pkg::M_TDATA_W-1:0]  m_tdata
);
    import msr_pkg::*;

    // A stalled result transaction holds its payload
    `MSR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    // Failed transactions carry equal roots (zero, or n for modulus two)
    `MSR_ASSERT_NOW(a_fail, m_tvalid && !m_tdata[OK_BIT], m_tdata[31:0] == m_tdata[63:32], "roots differ on failure")
    // Pad bits stay zero
    `MSR_ASSERT_NOW(a_pad, m_tvalid, m_tdata[M_TDATA_W-1:OK_BIT+1] == '0, "nonzero pad bits")
    // Reset empties the output register
    `MSR_ASSERT_RST(a_rst, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind modular_square_root_core msr_checker u_msr_checker (.*);

FILE: dv/modular_square_root_core_tb.sv
`default_nettype none

module modular_square_root_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msr_pkg::*;

    typedef struct packed {
        logic [31:0] modulus;
        logic [31:0] residue;
    } sqrt_req_t;

    typedef struct {
        logic [31:0] root_first;
        logic [31:0] root_second;
        logic        ok;
    } sqrt_roots_t;

    localparam int CLK_PERIOD     = 12;
    localparam int IDLE_PCT       = 34;
    localparam int RANDOM_ITEMS   = 77;
    localparam int BACKPRESS_AT   = 6;      // result count that starts the long hold-off
    localparam int BACKPRESS_LEN  = 60000;  // cycles
    localparam int DRAIN_CYCLES   = 20000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // residue, modulus
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // root_first, root_second, ok

    sqrt_req_t   pending_reqs[$];
    sqrt_roots_t expected_roots[$];
    int          mismatches;
    int          results_seen;
    int unsigned cyc;
    int          hold_left;
    bit          hold_done;
    bit          stim_done;

    modular_square_root_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Modular arithmetic, operands below m < 2^32
    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
        return (a * b) % m;
    endfunction

    function automatic longint unsigned powmod(longint unsigned base, longint unsigned ex,
                                               longint unsigned m);
        longint unsigned acc;
        acc  = 1 % m;
        base = base % m;
        while (ex != 0) begin
            if (ex[0]) acc = mulmod(acc, base, m);
            ex   = ex >> 1;
            base = mulmod(base, base, m);
        end
        return acc;
    endfunction

    // Tonelli-Shanks square roots, both roots and a valid flag
    function automatic sqrt_roots_t predict_roots(sqrt_req_t req);
        sqrt_roots_t     res;
        longint unsigned n, p, nr, q, s, half, z, c, r, t, m, i, tt, b;
        bit              found;
        n = req.residue;
        p = req.modulus;
        res.root_first  = '0;
        res.root_second = '0;
        res.ok          = 1'b0;
        if (p < 2) return res;
        if (p == 2) begin
            res.root_first  = n[31:0];
            res.root_second = n[31:0];
            res.ok          = n[0];
            return res;
        end
        if (p[0] == 1'b0) return res;
        nr   = n % p;
        half = (p - 1) >> 1;
        if (nr == 0 || powmod(nr, half, p) != 1) return res;
        q = p - 1;
        s = 0;
        while (q[0] == 1'b0) begin
            q = q >> 1;
            s++;
        end
        // least non-residue within the search bound
        found = 1'b0;
        z     = 2;
        for (int k = 0; k < SEARCH_LIMIT_DEF; k++) begin
            z = 2 + k;
            if (z >= p) break;
            if (powmod(z, half, p) == p - 1) begin
                found = 1'b1;
                break;
            end
        end
        if (!found) return res;
        c = powmod(z, q, p);
        r = powmod(nr, (q + 1) >> 1, p);
        t = powmod(nr, q, p);
        m = s;
        while (t != 1) begin
            i  = 1;
            tt = mulmod(t, t, p);
            while (i < m && tt != 1) begin
                tt = mulmod(tt, tt, p);
                i++;
            end
            if (i >= m) return res;
            b = c;
            for (longint unsigned j = 0; j + i + 1 < m; j++) b = mulmod(b, b, p);
            r = mulmod(r, b, p);
            t = mulmod(mulmod(t, b, p), b, p);
            c = mulmod(b, b, p);
            m = i;
        end
        if (mulmod(r, r, p) != nr) return res;
        res.root_first  = r[31:0];
        res.root_second = p[31:0] - r[31:0];
        res.ok          = 1'b1;
        return res;
    endfunction

    function automatic bit is_prime(longint unsigned x);
        if (x < 2) return 0;
        if (x < 4) return 1;
        if (x[0] == 1'b0) return 0;
        for (longint unsigned d = 3; d * d <= x; d += 2)
            if (x % d == 0) return 0;
        return 1;
    endfunction

    function automatic longint unsigned prime_from(longint unsigned x);
        if (x < 3) x = 3;
        x = x | 1;
        while (!is_prime(x)) begin
            x += 2;
            if (x > 64'hFFFF_FFFF) x = 3;
        end
        return x;
    endfunction

    // Residue that is a nonzero square mod p
    function automatic logic [31:0] square_mod(longint unsigned p);
        longint unsigned r;
        r = $urandom_range(1, 32'hFFFF_FFFF) % (p - 1) + 1;
        return 32'(mulmod(r, r, p));
    endfunction

    function automatic sqrt_req_t mk_req(logic [31:0] n, logic [31:0] p);
        sqrt_req_t req;
        req.residue = n;
        req.modulus = p;
        return req;
    endfunction

    // Append one request to the pending queue
    function automatic void add_req(logic [31:0] n, logic [31:0] p);
        pending_reqs = {pending_reqs, mk_req(n, p)};
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Idle windows: one long stretch with no idling
    function automatic bit idle_now();
        if (cyc > 200000 && cyc < 700000) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Driver: load the next transaction once the current one is taken
    always @(posedge aclk) begin
        sqrt_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            cyc      <= 0;
        end else begin
            cyc <= cyc + 1;
            if (s_tvalid && s_tready)
                expected_roots = {expected_roots, predict_roots(sqrt_req_t'(s_tdata))};
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && !idle_now()) begin
                    req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        sqrt_roots_t exp_r;
        logic [31:0] got_first, got_second;
        logic        got_ok;
        if (!aresetn) begin
            m_tready     <= 1'b0;
            results_seen <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_first  = m_tdata[31:0];
                got_second = m_tdata[63:32];
                got_ok     = m_tdata[OK_BIT];
                results_seen <= results_seen + 1;
                if (expected_roots.size() == 0) begin
                    $display("%0t: unexpected result first=%h second=%h ok=%b",
                             $time, got_first, got_second, got_ok);
                    mismatches++;
                end else begin
                    exp_r = expected_roots.pop_front();
                    if (got_first !== exp_r.root_first) begin
                        $display("%0t: root_first expected %h actual %h",
                                 $time, exp_r.root_first, got_first);
                        mismatches++;
                    end
                    if (got_second !== exp_r.root_second) begin
                        $display("%0t: root_second expected %h actual %h",
                                 $time, exp_r.root_second, got_second);
                        mismatches++;
                    end
                    if (got_ok !== exp_r.ok) begin
                        $display("%0t: ok expected %b actual %b", $time, exp_r.ok, got_ok);
                        mismatches++;
                    end
                end
            end
            // long hold-off so the output register fills and the input stalls
            if (!hold_done && results_seen == BACKPRESS_AT) begin
                hold_done <= 1'b1;
                hold_left <= BACKPRESS_LEN;
                m_tready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // Stimulus and end of run
    initial begin
        longint unsigned p;
        int              pick;
        mismatches = 0;
        stim_done  = 1'b0;
        aresetn    = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: modulus two, degenerate and even moduli, reduction, deep S
        add_req(32'd0, 32'd2);
        add_req(32'd1, 32'd2);
        add_req(32'hFFFF_FFFF, 32'd2);
        add_req(32'd5, 32'd0);
        add_req(32'hFFFF_FFFF, 32'd1);
        add_req(32'd4, 32'hFFFF_FFFE);
        add_req(32'd9, 32'd8);
        add_req(32'd0, 32'd7);
        add_req(32'd14, 32'd7);
        add_req(32'd2, 32'd7);
        add_req(32'd3, 32'd7);
        add_req(32'd11, 32'd7);
        add_req(32'd1, 32'd3);
        add_req(32'd2, 32'd3);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFB);
        add_req(square_mod(32'hFFFF_FFFB), 32'hFFFF_FFFB);
        add_req(square_mod(65537), 32'd65537);
        add_req(square_mod(998244353), 32'd998244353);
        add_req(square_mod(2013265921), 32'd2013265921);
        add_req(square_mod(32'd3221225473), 32'd3221225473);
        add_req(32'd1, 32'd561);    // non-residue search runs out
        add_req(32'd4, 32'd15);     // composite modulus
        add_req(32'd16, 32'd65);

        // random: mostly squares mod a prime, some noise and odd composites
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                p = prime_from($urandom_range(3, 1000));
            else
                p = prime_from($urandom);
            if (pick < 55)
                add_req(square_mod(p), 32'(p));
            else if (pick < 75)
                add_req($urandom, 32'(p));
            else if (pick < 85)
                add_req($urandom, $urandom | 32'd1);
            else if (pick < 92)
                add_req($urandom, $urandom);
            else
                add_req($urandom, 32'd2);
        end

        wait (pending_reqs.size() == 0 && !s_tvalid);
        @(posedge aclk);
        wait (expected_roots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit
    initial begin
        #1000ms;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
